FILE: hw/rtl/multi_port_input_debouncer_defines.svh
// assertion macros for the multi-port input debouncer
`ifndef MULTI_PORT_INPUT_DEBOUNCER_DEFINES_SVH
`define MULTI_PORT_INPUT_DEBOUNCER_DEFINES_SVH

// same-cycle implication
`define MPID_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MPID_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/mpid_pkg.sv
// types, codes and constants of the multi-port input debouncer
`timescale 1ns / 1ps

package mpid_pkg;

  localparam int DEFAULT_NUM_PORTS   = 32;
  localparam int DEFAULT_SUBSCRIBERS = 4;

  localparam int PORT_W   = 5;
  localparam int HOLD_W   = 16;
  localparam int PERIOD_W = 8;
  localparam int COUNT_W  = 17;
  localparam int NOTIFY_W = 4;

  localparam logic [PERIOD_W-1:0] RESET_PERIOD = 8'd40;

  localparam logic [1:0] OP_SAMPLE   = 2'd0;
  localparam logic [1:0] OP_INSTALL  = 2'd1;
  localparam logic [1:0] OP_STATUS   = 2'd2;
  localparam logic [1:0] OP_RESERVED = 2'd3;

  localparam logic [1:0] EDGE_NONE = 2'd0;
  localparam logic [1:0] EDGE_RISE = 2'd1;
  localparam logic [1:0] EDGE_FALL = 2'd2;

  localparam logic [1:0] INST_NONE      = 2'd0;
  localparam logic [1:0] INST_OK        = 2'd1;
  localparam logic [1:0] INST_EMPTY_MODE = 2'd2;
  localparam logic [1:0] INST_FULL      = 2'd3;

  typedef struct packed {
    logic [1:0]        operation;
    logic [PORT_W-1:0] port;
    logic              level;
    logic              bypass_filter;
    logic [HOLD_W-1:0] hold_high_ms;
    logic [HOLD_W-1:0] hold_low_ms;
    logic [1:0]        trigger_mode;
  } request_t;

  typedef struct packed {
    logic [1:0]          edge_event;
    logic [PORT_W-1:0]   event_port;
    logic [NOTIFY_W-1:0] notify_mask;
    logic [1:0]          install_result;
    logic                instant_level;
    logic                filtered_level;
  } result_t;

endpackage

FILE: hw/rtl/multi_port_input_debouncer.sv
// Per-port debounce filter with edge subscribers. Takes one request per clock cycle
// while the result is not stalled: at acceptance the addressed port's state is read
// from a state memory with one read and one write port into a register (with
// forwarding from the write of the request just ahead), and when the request advances
// the hold counter, the filtered level and the subscriber slots are updated, the port's
// state is written back and the result register is loaded. A stalled result holds the
// request behind it. Per-port valid bits cleared by reset make every port read as zero
// state right after reset, so no clearing pass is needed. The sample period register is
// written through the cfg channel, which is always ready.
`timescale 1ns / 1ps
`include "multi_port_input_debouncer_defines.svh"

module multi_port_input_debouncer #(
  parameter int NUM_PORTS   = mpid_pkg::DEFAULT_NUM_PORTS,
  parameter int SUBSCRIBERS = mpid_pkg::DEFAULT_SUBSCRIBERS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          request_valid,
  output logic                          request_stall,
  input  mpid_pkg::request_t            request,
  output logic                          result_valid,
  input  logic                          result_stall,
  output mpid_pkg::result_t             result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mpid_pkg::PERIOD_W-1:0] cfg_data
);

  localparam int AW = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
  localparam int WW = AW + mpid_pkg::PORT_W;
  localparam int MW = 2 * SUBSCRIBERS;

  typedef struct packed {
    logic [MW-1:0]                modes;
    logic                         qual;
    logic [mpid_pkg::COUNT_W-1:0] count;
    logic                         prev;
  } entry_t;

  logic [mpid_pkg::PERIOD_W-1:0] period;

  logic               request_accept;
  logic               out_open;
  logic               s1_valid;
  logic               s1_advance;
  mpid_pkg::request_t s1;

  logic [WW-1:0] req_port_wide;
  logic [AW-1:0] req_addr;
  logic [WW-1:0] s1_port_wide;
  logic [AW-1:0] s1_addr;
  logic          s1_in_range;

  entry_t                 mem [NUM_PORTS];
  logic [NUM_PORTS-1:0]   vld;
  entry_t                 rd_mem;
  logic                   rd_vld;
  logic                   rd_fwd;
  entry_t                 fwd_data;
  entry_t                 cur;

  logic   wr_en;
  entry_t entry_next;

  logic [mpid_pkg::HOLD_W-1:0]  hold_sel;
  logic [mpid_pkg::HOLD_W-1:0]  hold;
  logic [mpid_pkg::COUNT_W-1:0] count_sum;
  logic [1:0]                   edge_code;
  logic [SUBSCRIBERS-1:0]       mask;
  logic                         slot_found;
  mpid_pkg::result_t            result_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      period <= mpid_pkg::RESET_PERIOD;
    end else if (cfg_valid && cfg_ready) begin
      period <= cfg_data;
    end
  end

  // handshake
  assign out_open       = !result_valid || !result_stall;
  assign s1_advance     = s1_valid && out_open;
  assign request_stall  = s1_valid && !out_open;
  assign request_accept = request_valid && !request_stall;

  assign req_port_wide = WW'(request.port);
  assign req_addr      = req_port_wide[AW-1:0];
  assign s1_port_wide  = WW'(s1.port);
  assign s1_addr       = s1_port_wide[AW-1:0];
  assign s1_in_range   = s1_port_wide < WW'(NUM_PORTS);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (request_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (request_accept) begin
      s1 <= request;
    end
  end

  // state memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[s1_addr] <= entry_next;
    end
  end

  always_ff @(posedge clk) begin
    if (request_accept) begin
      rd_mem <= mem[req_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[s1_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (request_accept) begin
      rd_vld   <= vld[req_addr];
      rd_fwd   <= wr_en && (s1_addr == req_addr);
      fwd_data <= entry_next;
    end
  end

  assign cur = rd_fwd ? fwd_data : (rd_vld ? rd_mem : '0);

  // update
  assign hold_sel  = s1.level ? s1.hold_high_ms : s1.hold_low_ms;
  assign hold      = (hold_sel == '0) ? mpid_pkg::HOLD_W'(period) : hold_sel;
  assign count_sum = cur.count + mpid_pkg::COUNT_W'(period);

  always_comb begin
    entry_next = cur;
    wr_en      = 1'b0;
    edge_code  = mpid_pkg::EDGE_NONE;
    mask       = '0;
    slot_found = 1'b0;
    result_next                = '0;
    result_next.event_port     = s1.port;
    unique case (s1.operation)
      mpid_pkg::OP_SAMPLE: begin
        if (s1_in_range) begin
          wr_en = s1_advance;
          if (s1.bypass_filter) begin
            entry_next.prev = s1.level;
            entry_next.qual = s1.level;
          end else if (s1.level != cur.prev) begin
            entry_next.count = '0;
            entry_next.prev  = s1.level;
          end else if (cur.count < mpid_pkg::COUNT_W'(hold)) begin
            entry_next.count = count_sum;
            if (count_sum >= mpid_pkg::COUNT_W'(hold)) begin
              entry_next.qual = s1.level;
            end
          end
          if (entry_next.qual != cur.qual) begin
            edge_code = entry_next.qual ? mpid_pkg::EDGE_RISE : mpid_pkg::EDGE_FALL;
            for (int s = 0; s < SUBSCRIBERS; s++) begin
              mask[s] = |(cur.modes[2*s +: 2] & edge_code);
            end
          end
        end
        result_next.edge_event  = edge_code;
        result_next.notify_mask = mpid_pkg::NOTIFY_W'(mask);
      end
      mpid_pkg::OP_INSTALL: begin
        if (s1.trigger_mode == 2'd0) begin
          result_next.install_result = mpid_pkg::INST_EMPTY_MODE;
        end else if (!s1_in_range) begin
          result_next.install_result = mpid_pkg::INST_FULL;
        end else begin
          for (int s = 0; s < SUBSCRIBERS; s++) begin
            if (!slot_found && cur.modes[2*s +: 2] == 2'd0) begin
              entry_next.modes[2*s +: 2] = s1.trigger_mode;
              slot_found                 = 1'b1;
            end
          end
          wr_en = s1_advance && slot_found;
          result_next.install_result = slot_found ? mpid_pkg::INST_OK : mpid_pkg::INST_FULL;
        end
      end
      mpid_pkg::OP_STATUS: begin
        result_next.install_result = mpid_pkg::INST_NONE;
      end
      default: begin
        result_next.install_result = mpid_pkg::INST_NONE;
      end
    endcase
    if (s1_in_range && s1.operation != mpid_pkg::OP_RESERVED) begin
      result_next.instant_level  = entry_next.prev;
      result_next.filtered_level = entry_next.qual;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      result <= result_next;
    end
  end

  `MPID_ASSERT_NOW(a_edge_not_install,
    result_valid && result.edge_event != mpid_pkg::EDGE_NONE,
    result.install_result == mpid_pkg::INST_NONE, "edge reported on an install result")
  `MPID_ASSERT_NOW(a_mask_needs_edge, result_valid && result.notify_mask != '0,
    result.edge_event != mpid_pkg::EDGE_NONE, "notify mask without an edge")
  `MPID_ASSERT_NEXT(a_advance_fills_out, s1_advance, result_valid, "advanced request lost")
  `MPID_ASSERT_NOW(a_stall_needs_busy, request_stall, s1_valid && result_valid,
    "stall with empty pipeline")

endmodule
